[src/shell_line_syntax_checker_macros.svh]
// Assertion helpers shared by the checker RTL.
`ifndef SHELL_LINE_SYNTAX_CHECKER_MACROS_SVH
`define SHELL_LINE_SYNTAX_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slsc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slsc: next-cycle check failed");

`endif

[src/slsc_pkg.sv]
`default_nettype none

package slsc_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 4;
    localparam int STATUS_W = 8;

    localparam logic [BYTE_W-1:0] CH_PIPE  = 8'h7C;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_SQ    = 8'h27;
    localparam logic [BYTE_W-1:0] CH_DQ    = 8'h22;

    localparam logic [STATUS_W-1:0] STATUS_NONE  = 8'd0;
    localparam logic [STATUS_W-1:0] STATUS_PIPE  = 8'd130;
    localparam logic [STATUS_W-1:0] STATUS_OTHER = 8'd2;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PIPE = 2'd1,
        OP_GT   = 2'd2,
        OP_LT   = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        ERR_NONE           = 4'd0,
        ERR_LEADING_PIPE   = 4'd1,
        ERR_PIPE_PIPE      = 4'd2,
        ERR_REDIR_PIPE     = 4'd3,
        ERR_PIPE_REDIR     = 4'd4,
        ERR_SPLIT_GREATER  = 4'd5,
        ERR_TRAILING_PIPE  = 4'd6,
        ERR_TRAILING_REDIR = 4'd7,
        ERR_UNCLOSED_QUOTE = 4'd8
    } err_t;

    // Exit status that the shell reports for a given syntax error.
    function automatic logic [STATUS_W-1:0] status_of(err_t kind);
        logic [STATUS_W-1:0] status;
        priority if (kind == ERR_NONE)
            status = STATUS_NONE;
        else if (kind == ERR_LEADING_PIPE || kind == ERR_TRAILING_PIPE)
            status = STATUS_PIPE;
        else
            status = STATUS_OTHER;
        return status;
    endfunction

endpackage

`default_nettype wire

[src/slsc_line_if.sv]
`default_nettype none

interface slsc_line_if
    import slsc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] line_byte;
    logic              end_of_line;

    modport source (output valid, output line_byte, output end_of_line, input ready);
    modport sink   (input valid, input line_byte, input end_of_line, output ready);
endinterface

`default_nettype wire

[src/slsc_result_if.sv]
`default_nettype none

interface slsc_result_if
    import slsc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   error_kind;
    logic [STATUS_W-1:0] exit_status;

    modport source (output valid, output error_kind, output exit_status, input ready);
    modport sink   (input valid, input error_kind, input exit_status, output ready);
endinterface

`default_nettype wire

[src/shell_line_syntax_checker.sv]
// Shell command-line syntax checker.
// The line_in channel carries one character of a command line per beat; a beat
// with end_of_line set closes the line and carries no character. For each line
// exactly one beat leaves on the result channel: error_kind names the first
// syntax error found (or zero) and exit_status gives the status a shell would
// set (130 for a leading or trailing pipe, 2 for other errors, 0 for none).
// Character beats are absorbed at one per cycle while line_in is ready and
// produce no output beat. The result of an end beat is registered and is
// offered on result the cycle after the end beat is taken, and a new beat of
// any kind can be taken every cycle while line_in is ready; the rate is set by
// the update of the per-line flag registers.
// If the receiver stalls while a result is waiting, line_in stays ready only
// when the waiting result is taken in the same cycle; otherwise line_in is
// held off until the result register drains, so no result is ever lost.
// Reset clears the quote flags, the pending operator, the latched error and
// the result valid flag; the block then expects the start of a new line. After
// each end beat the line state returns to the same cleared values.
`default_nettype none
`include "shell_line_syntax_checker_macros.svh"

module shell_line_syntax_checker
    import slsc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    slsc_line_if.sink     line_in,
    slsc_result_if.source result
);

    // Per-line scan state.
    logic              in_sq_reg, in_sq_next;
    logic              in_dq_reg, in_dq_next;
    logic              seen_reg, seen_next;
    op_t               pend_reg, pend_next;
    logic              space_after_reg, space_after_next;
    logic [BYTE_W-1:0] last_reg, last_next;
    err_t              latched_reg, latched_next;

    // Result holding register.
    logic                out_valid_reg, out_valid_next;
    err_t                kind_reg, kind_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic              accept;
    logic              end_accept;
    logic [BYTE_W-1:0] c;
    err_t              pair_err;
    err_t              final_kind;
    logic              c_is_redir;
    logic              last_is_redir;

    // Taking a beat is safe whenever the result register is empty or drains now.
    assign line_in.ready = !out_valid_reg || result.ready;
    assign accept        = line_in.valid && line_in.ready;
    assign end_accept    = accept && line_in.end_of_line;
    assign c             = line_in.line_byte;
    assign c_is_redir    = (c == CH_GT) || (c == CH_LT);
    assign last_is_redir = (last_reg == CH_GT) || (last_reg == CH_LT);

    // Error raised by the byte that follows a pending operator.
    always_comb
    begin
        pair_err = ERR_NONE;
        unique case (pend_reg)
            OP_PIPE:
            begin
                if (c == CH_PIPE)
                    pair_err = ERR_PIPE_PIPE;
                else if (c_is_redir)
                    pair_err = ERR_PIPE_REDIR;
            end
            OP_GT:
            begin
                if (c == CH_PIPE)
                    pair_err = ERR_REDIR_PIPE;
                else if (c == CH_GT && space_after_reg)
                    pair_err = ERR_SPLIT_GREATER;
            end
            OP_LT:
            begin
                if (c == CH_PIPE)
                    pair_err = ERR_REDIR_PIPE;
            end
            OP_NONE:
            begin
                pair_err = ERR_NONE;
            end
        endcase
    end

    // Verdict at the end of the line; the trailing checks ignore quoting.
    always_comb
    begin
        final_kind = latched_reg;
        if (latched_reg == ERR_NONE && seen_reg)
        begin
            priority if (last_reg == CH_PIPE)
                final_kind = ERR_TRAILING_PIPE;
            else if (last_is_redir)
                final_kind = ERR_TRAILING_REDIR;
            else if (in_sq_reg || in_dq_reg)
                final_kind = ERR_UNCLOSED_QUOTE;
            else
                final_kind = ERR_NONE;
        end
    end

    // Scan state update for one accepted beat.
    always_comb
    begin
        in_sq_next       = in_sq_reg;
        in_dq_next       = in_dq_reg;
        seen_next        = seen_reg;
        pend_next        = pend_reg;
        space_after_next = space_after_reg;
        last_next        = last_reg;
        latched_next     = latched_reg;

        if (end_accept)
        begin
            in_sq_next       = 1'b0;
            in_dq_next       = 1'b0;
            seen_next        = 1'b0;
            pend_next        = OP_NONE;
            space_after_next = 1'b0;
            last_next        = '0;
            latched_next     = ERR_NONE;
        end
        else if (accept && latched_reg == ERR_NONE)
        begin
            if (c == CH_SPACE)
            begin
                if (pend_reg != OP_NONE)
                    space_after_next = 1'b1;
            end
            else
            begin
                seen_next = 1'b1;
                last_next = c;
                if (!seen_reg && c == CH_PIPE)
                begin
                    // A pipe as the first word of the line.
                    latched_next = ERR_LEADING_PIPE;
                end
                else if (pair_err != ERR_NONE)
                begin
                    latched_next     = pair_err;
                    pend_next        = OP_NONE;
                    space_after_next = 1'b0;
                end
                else
                begin
                    pend_next        = OP_NONE;
                    space_after_next = 1'b0;
                    priority if (c == CH_SQ && !in_dq_reg)
                        in_sq_next = !in_sq_reg;
                    else if (c == CH_DQ && !in_sq_reg)
                        in_dq_next = !in_dq_reg;
                    else if (!in_sq_reg && !in_dq_reg)
                    begin
                        priority if (c == CH_PIPE)
                            pend_next = OP_PIPE;
                        else if (c == CH_GT)
                            pend_next = OP_GT;
                        else if (c == CH_LT)
                            pend_next = OP_LT;
                        else
                            pend_next = OP_NONE;
                    end
                    else
                        pend_next = OP_NONE;
                end
            end
        end
    end

    // Result register: loaded by an end beat, emptied when the receiver takes it.
    always_comb
    begin
        kind_next   = kind_reg;
        status_next = status_reg;
        if (end_accept)
        begin
            out_valid_next = 1'b1;
            kind_next      = final_kind;
            status_next    = status_of(final_kind);
        end
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sq_reg       <= 1'b0;
            in_dq_reg       <= 1'b0;
            seen_reg        <= 1'b0;
            pend_reg        <= OP_NONE;
            space_after_reg <= 1'b0;
            last_reg        <= '0;
            latched_reg     <= ERR_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            in_sq_reg       <= in_sq_next;
            in_dq_reg       <= in_dq_next;
            seen_reg        <= seen_next;
            pend_reg        <= pend_next;
            space_after_reg <= space_after_next;
            last_reg        <= last_next;
            latched_reg     <= latched_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        status_reg <= status_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.error_kind  = kind_reg;
    assign result.exit_status = status_reg;

    // An end beat always leaves a result behind and a cleared line state.
    `SLSC_ASSERT_NEXT(a_end_gives_result, clk, rst_n, end_accept,
        out_valid_reg && !seen_reg && latched_reg == ERR_NONE)

    // A latched error is kept until the end of the line.
    `SLSC_ASSERT_NEXT(a_latch_holds, clk, rst_n,
        accept && !line_in.end_of_line && latched_reg != ERR_NONE,
        latched_reg == $past(latched_reg))

    // An operator is only held outside quotes and after a non-space byte.
    `SLSC_ASSERT_SAME(a_pend_unquoted, clk, rst_n, pend_reg != OP_NONE,
        seen_reg && !in_sq_reg && !in_dq_reg)

    // The status code agrees with the error kind it is reported with.
    `SLSC_ASSERT_SAME(a_status_matches, clk, rst_n, out_valid_reg,
        (kind_reg == ERR_NONE) == (status_reg == STATUS_NONE))

endmodule

`default_nettype wire

[bench/shell_line_syntax_checker_tb.sv]
`default_nettype none

// Self-checking bench for the shell command-line syntax checker.
//
// Lines are fed into line_in one character per beat and closed by an end beat.
// A monitor watches both channels at every rising edge. Each accepted
// character beat goes through a local model of the line scanner. Each accepted
// end beat turns the model state into the expected verdict, which is queued
// in order. Every beat that leaves on the result channel is compared, field by
// field, with the oldest queued verdict.
//
// The stimulus has a short directed part and then a long random part.
// The directed part is a table of lines that covers every error kind, the
// blank cases, the byte extremes and the quoting corner cases. The random part
// is mostly well-formed pipelines with random words, quoting and redirections,
// some of them with a planted defect, plus random character soup and blank
// lines.
module shell_line_syntax_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slsc_pkg::*;

    // Input beats to send, directed part included.
    localparam int TOTAL_BEATS = 1050;
    // Generous ceiling. The slow path is the random gap before every beat plus
    // the receiver stalls and the single long hold-off.
    localparam int CYCLE_LIMIT = 400000;
    // The result is registered from its end beat, so a short drain is enough.
    localparam int DRAIN_CYCLES = 8;
    // The receiver shuts its door for a long stretch once, early in the random
    // part, so that a finished verdict backs up and line_in is stalled.
    localparam int PRESSURE_AT = 20;
    localparam int PRESSURE_CYCLES = 300;

    typedef struct packed {
        err_t        kind;
        logic [7:0]  status;
    } verdict_t;

    // One note travels with every end beat. A typed note carries a verdict that
    // was written into the directed table by hand. It replaces the verdict of
    // the local model.
    typedef struct packed {
        logic        typed;
        err_t        kind;
        logic [7:0]  status;
    } line_note_t;

    logic clk;
    logic rst_n;

    slsc_line_if   line_bus ();
    slsc_result_if res_bus ();

    shell_line_syntax_checker DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .line_in(line_bus),
        .result (res_bus)
    );

    // Directed lines. A line with the typed flag set is checked against the
    // verdict in the same row. The other lines are checked against the model.
    //   empty line, all-space line, leading pipe with a quote after the latch
    //   (the quote must be ignored), pipe pipe, redirection then pipe, pipe
    //   then redirection, greater signs split by a space, trailing pipe (still
    //   pending at the end), trailing redirection, unclosed quote, the highest
    //   byte value and the lowest nonzero one, a quoted trailing greater (the
    //   trailing check ignores quoting), and a quoted pipe after a pending
    //   greater (the opening quote is the follower, so the pipe raises no error).
    localparam int DIRECTED_LINES = 13;
    string directed_text [DIRECTED_LINES] = '{
        "", "  ", "|'", "a||", ">|", "a|<", "> >", "a|", "a<", "\"",
        "\377\001", "'>", ">\"|\""
    };
    logic directed_typed [DIRECTED_LINES] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b0, 1'b0
    };
    // The last two rows are left to the model, so their entries here are unused.
    err_t directed_kind [DIRECTED_LINES] = '{
        ERR_NONE, ERR_NONE, ERR_LEADING_PIPE, ERR_PIPE_PIPE, ERR_REDIR_PIPE,
        ERR_PIPE_REDIR, ERR_SPLIT_GREATER, ERR_TRAILING_PIPE, ERR_TRAILING_REDIR,
        ERR_UNCLOSED_QUOTE, ERR_NONE, ERR_NONE, ERR_NONE
    };
    logic [7:0] directed_status [DIRECTED_LINES] = '{
        STATUS_NONE, STATUS_NONE, STATUS_PIPE, STATUS_OTHER, STATUS_OTHER,
        STATUS_OTHER, STATUS_OTHER, STATUS_PIPE, STATUS_OTHER, STATUS_OTHER,
        STATUS_NONE, STATUS_NONE, STATUS_NONE
    };

    // Local model of the line scanner. It is cleared at every end beat, which
    // matches the state after reset.
    logic       in_single = 1'b0;
    logic       in_double = 1'b0;
    logic       got_text = 1'b0;
    op_t        held_op = OP_NONE;
    logic       gap_after_op = 1'b0;
    logic [7:0] last_char = 8'd0;
    err_t       first_err = ERR_NONE;

    verdict_t   pending_verdicts [$];
    line_note_t typed_notes [$];
    logic [7:0] line_buf [$];

    int  mismatches = 0;
    int  live_beats = 0;
    logic steady_sender = 1'b0;

    // Advances the scanner by one character beat.
    function automatic void scan_char(input logic [7:0] c);
        err_t pair;
        pair = ERR_NONE;
        // Once an error is latched the rest of the line is ignored.
        if (first_err != ERR_NONE)
            return;
        // Only 0x20 counts as a space. It only marks a gap after an operator.
        if (c == CH_SPACE)
        begin
            if (held_op != OP_NONE)
                gap_after_op = 1'b1;
            return;
        end
        if (!got_text)
        begin
            got_text = 1'b1;
            if (c == CH_PIPE)
            begin
                first_err = ERR_LEADING_PIPE;
                last_char = c;
                return;
            end
        end
        // The first non-space byte after an operator decides the pair error,
        // whether or not that byte is quoted.
        if (held_op != OP_NONE)
        begin
            case (held_op)
                OP_PIPE:
                begin
                    if (c == CH_PIPE)
                        pair = ERR_PIPE_PIPE;
                    else if (c == CH_GT || c == CH_LT)
                        pair = ERR_PIPE_REDIR;
                end
                OP_GT:
                begin
                    if (c == CH_PIPE)
                        pair = ERR_REDIR_PIPE;
                    else if (c == CH_GT && gap_after_op)
                        pair = ERR_SPLIT_GREATER;
                end
                OP_LT:
                begin
                    if (c == CH_PIPE)
                        pair = ERR_REDIR_PIPE;
                end
                default: ;
            endcase
            held_op = OP_NONE;
            gap_after_op = 1'b0;
            if (pair != ERR_NONE)
            begin
                first_err = pair;
                last_char = c;
                return;
            end
        end
        if (c == CH_SQ && !in_double)
            in_single = !in_single;
        else if (c == CH_DQ && !in_single)
            in_double = !in_double;
        else if (!in_single && !in_double)
        begin
            if (c == CH_PIPE)
                held_op = OP_PIPE;
            else if (c == CH_GT)
                held_op = OP_GT;
            else if (c == CH_LT)
                held_op = OP_LT;
        end
        last_char = c;
    endfunction

    // Works out the verdict of the line at its end beat and clears the scanner.
    // The trailing checks look at the last non-space byte even when it sat
    // inside quotes.
    function automatic verdict_t close_line();
        verdict_t v;
        v.kind = first_err;
        if (v.kind == ERR_NONE && got_text)
        begin
            if (last_char == CH_PIPE)
                v.kind = ERR_TRAILING_PIPE;
            else if (last_char == CH_GT || last_char == CH_LT)
                v.kind = ERR_TRAILING_REDIR;
            else if (in_single || in_double)
                v.kind = ERR_UNCLOSED_QUOTE;
        end
        case (v.kind)
            ERR_NONE:                            v.status = STATUS_NONE;
            ERR_LEADING_PIPE, ERR_TRAILING_PIPE: v.status = STATUS_PIPE;
            default:                             v.status = STATUS_OTHER;
        endcase
        in_single = 1'b0;
        in_double = 1'b0;
        got_text = 1'b0;
        held_op = OP_NONE;
        gap_after_op = 1'b0;
        last_char = 8'd0;
        first_err = ERR_NONE;
        return v;
    endfunction

    // Appends a run of spaces.
    function automatic void put_spaces(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) line_buf.push_back(CH_SPACE);
    endfunction

    // Appends one word. Most words are plain letters and digits. Some are
    // quoted chunks that hide operators and spaces. A few of those chunks are
    // left open.
    function automatic void put_word();
        logic [7:0] quote;
        logic [7:0] other;
        int n;
        if ($urandom_range(0, 4) == 0)
        begin
            quote = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
            other = (quote == CH_SQ) ? CH_DQ : CH_SQ;
            line_buf.push_back(quote);
            n = $urandom_range(0, 4);
            repeat (n)
            begin
                case ($urandom_range(0, 5))
                    0: line_buf.push_back(CH_SPACE);
                    1: line_buf.push_back(CH_PIPE);
                    2: line_buf.push_back(CH_GT);
                    3: line_buf.push_back(CH_LT);
                    4: line_buf.push_back(other);
                    default: line_buf.push_back(8'("a") + 8'($urandom_range(0, 25)));
                endcase
            end
            if ($urandom_range(0, 7) != 0)
                line_buf.push_back(quote);
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                if ($urandom_range(0, 3) == 0)
                    line_buf.push_back(8'("0") + 8'($urandom_range(0, 9)));
                else
                    line_buf.push_back(8'("a") + 8'($urandom_range(0, 25)));
            end
        end
    endfunction

    // Offers one beat on line_in after a random gap and returns at the edge
    // that takes it. valid stays high when the next beat follows without a gap.
    task automatic send_beat(input logic [7:0] b, input logic eol);
        int gap;
        gap = steady_sender ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            line_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        line_bus.valid       <= 1'b1;
        line_bus.line_byte   <= b;
        line_bus.end_of_line <= eol;
        do
            @(posedge clk);
        while (line_bus.ready !== 1'b1);
    endtask

    // Sends the characters in line_buf and then the end beat. The note is
    // queued before the end beat goes out, so the monitor finds it in order.
    // About one line in four goes out with no gaps at all.
    task automatic send_line(input line_note_t note);
        steady_sender = ($urandom_range(0, 3) == 0);
        foreach (line_buf[i])
            send_beat(line_buf[i], 1'b0);
        typed_notes.push_back(note);
        // The byte of an end beat is ignored, so it is random.
        send_beat(8'($urandom_range(1, 255)), 1'b1);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog. It counts cycles and ends a run that hangs.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("shell_line_syntax_checker test failed");
        $finish;
    end

    // Monitor. Both channels are sampled at the rising edge, before any
    // nonblocking update of that edge lands. An input beat is taken into the
    // model first. Then a result beat is checked against the oldest verdict.
    always @(posedge clk)
    begin : monitor
        verdict_t   want;
        line_note_t note;
        if (rst_n)
        begin
            if (line_bus.valid && line_bus.ready)
            begin
                live_beats++;
                if (line_bus.end_of_line)
                begin
                    want = close_line();
                    if (typed_notes.size() != 0)
                    begin
                        note = typed_notes.pop_front();
                        if (note.typed)
                        begin
                            want.kind = note.kind;
                            want.status = note.status;
                        end
                    end
                    pending_verdicts.push_back(want);
                end
                else
                    scan_char(line_bus.line_byte);
            end
            if (res_bus.valid && res_bus.ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("result beat with no line waiting: error_kind %0d exit_status %0d",
                           res_bus.error_kind, res_bus.exit_status);
                    mismatches++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (res_bus.error_kind !== want.kind)
                    begin
                        $error("error_kind: expected %0d, got %0d",
                               want.kind, res_bus.error_kind);
                        mismatches++;
                    end
                    if (res_bus.exit_status !== want.status)
                    begin
                        $error("exit_status: expected %0d, got %0d",
                               want.status, res_bus.exit_status);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Result side. It stalls a random number of cycles before each beat and
    // sometimes runs a stretch of eight beats with no stall at all. Once it
    // holds ready low for a long stretch while the sender keeps going.
    initial
    begin : result_side
        int   stall;
        int   taken;
        logic steady;
        taken = 0;
        steady = 1'b0;
        res_bus.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (taken % 8 == 0)
                steady = ($urandom_range(0, 3) == 0);
            stall = steady ? 0 : $urandom_range(0, 13);
            if (taken == PRESSURE_AT)
                stall = PRESSURE_CYCLES;
            if (stall > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_bus.valid !== 1'b1);
            taken++;
        end
    end

    // Line side and the end of the run.
    initial
    begin : line_side
        int         style;
        int         n;
        int         pos;
        logic [7:0] first_c;
        logic [7:0] second_c;
        line_note_t note;

        rst_n <= 1'b0;
        line_bus.valid       <= 1'b0;
        line_bus.line_byte   <= 8'd0;
        line_bus.end_of_line <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < DIRECTED_LINES; row++)
        begin
            line_buf.delete();
            for (int i = 0; i < directed_text[row].len(); i++)
                line_buf.push_back(directed_text[row][i]);
            note.typed = directed_typed[row];
            note.kind = directed_kind[row];
            note.status = directed_status[row];
            send_line(note);
        end

        // Random lines. Most are pipelines of commands with words, quoting and
        // redirections, and some of those carry one planted defect. The rest
        // are character soup that leans on operators and quotes, or blank lines.
        while (live_beats < TOTAL_BEATS)
        begin
            line_buf.delete();
            style = $urandom_range(0, 99);
            if (style < 5)
                put_spaces(0, 3);
            else if (style < 30)
            begin
                n = $urandom_range(1, 16);
                repeat (n)
                begin
                    case ($urandom_range(0, 11))
                        0, 1, 2: line_buf.push_back(CH_SPACE);
                        3:       line_buf.push_back(CH_PIPE);
                        4:       line_buf.push_back(CH_GT);
                        5:       line_buf.push_back(CH_LT);
                        6:       line_buf.push_back(CH_SQ);
                        7:       line_buf.push_back(CH_DQ);
                        8, 9, 10: line_buf.push_back(8'("a") + 8'($urandom_range(0, 25)));
                        default: line_buf.push_back(8'($urandom_range(1, 255)));
                    endcase
                end
            end
            else
            begin
                put_spaces(0, 1);
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                begin
                    if (k > 0)
                    begin
                        put_spaces(0, 2);
                        line_buf.push_back(CH_PIPE);
                        put_spaces(0, 2);
                    end
                    put_word();
                    if ($urandom_range(0, 1) == 0)
                    begin
                        put_spaces(1, 2);
                        put_word();
                    end
                    if ($urandom_range(0, 2) == 0)
                    begin
                        put_spaces(0, 2);
                        case ($urandom_range(0, 2))
                            0: line_buf.push_back(CH_GT);
                            1: line_buf.push_back(CH_LT);
                            default:
                            begin
                                // An append redirection: two greater signs with
                                // no gap are legal.
                                line_buf.push_back(CH_GT);
                                line_buf.push_back(CH_GT);
                            end
                        endcase
                        put_spaces(0, 2);
                        put_word();
                    end
                end
                put_spaces(0, 2);

                if (style >= 85)
                begin
                    pos = $urandom_range(0, line_buf.size());
                    first_c = CH_PIPE;
                    second_c = CH_PIPE;
                    case ($urandom_range(0, 6))
                        0: line_buf.push_back(CH_PIPE);
                        1: line_buf.push_back($urandom_range(0, 1) ? CH_GT : CH_LT);
                        2: line_buf.push_front(CH_PIPE);
                        3: ;
                        4: first_c = $urandom_range(0, 1) ? CH_GT : CH_LT;
                        5: second_c = $urandom_range(0, 1) ? CH_GT : CH_LT;
                        default:
                        begin
                            first_c = CH_GT;
                            second_c = CH_GT;
                            line_buf.insert(pos, CH_SPACE);
                        end
                    endcase
                    if (first_c != CH_PIPE || second_c != CH_PIPE
                        || line_buf.size() == 0 || $urandom_range(0, 1) == 0)
                    begin
                        line_buf.insert(pos, second_c);
                        line_buf.insert(pos, first_c);
                    end
                end
            end
            note = '0;
            send_line(note);
        end

        // The last beat was taken at this edge. Let the monitor see it before
        // waiting for the verdicts to drain.
        line_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("shell_line_syntax_checker test passed");
        else
            $display("shell_line_syntax_checker test failed");
        $finish;
    end

endmodule

`default_nettype wire
